// ----- rtl/core/r4fft_pkg.sv -----
// shared constants and register codes for the radix-4 fft butterfly core
// no dependencies
package r4fft_pkg;

  localparam int SAMPLE_WIDTH_DEF      = 24;
  localparam int TWIDDLE_FRAC_BITS_DEF = 30;
  localparam int TW_W                  = 32;
  localparam int NUM_REGS              = 4;
  localparam int CFG_IDX_W             = $clog2(NUM_REGS);
  localparam int NUM_COMP              = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_A_RE = 2'd0,
    REG_A_IM = 2'd1,
    REG_B_RE = 2'd2,
    REG_B_IM = 2'd3
  } cfg_reg_e;

endpackage

// ----- rtl/core/r4fft_cmul.sv -----
// one complex multiply lane: registered partial products, then a single half-up rounding
// uses r4fft_pkg for the twiddle width
module r4fft_cmul #(
  parameter int IN_W = 24,
  parameter int FRAC = 30,
  parameter int RW   = IN_W + 33 - FRAC
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [r4fft_pkg::TW_W-1:0] tw_re_i,
  input  logic signed [r4fft_pkg::TW_W-1:0] tw_im_i,
  input  logic signed [IN_W-1:0]            pass_re_i,
  input  logic signed [IN_W-1:0]            pass_im_i,
  input  logic signed [IN_W-1:0]            x_re_i,
  input  logic signed [IN_W-1:0]            x_im_i,
  output logic signed [IN_W-1:0]            pass_re_o,
  output logic signed [IN_W-1:0]            pass_im_o,
  output logic signed [RW-1:0]              y_re_o,
  output logic signed [RW-1:0]              y_im_o
);
  import r4fft_pkg::*;

  localparam int PW   = IN_W + TW_W;
  localparam int SUMW = PW + 1;
  localparam logic signed [SUMW-1:0] RND = {{(SUMW-1){1'b0}}, 1'b1} << (FRAC - 1);

  logic signed [PW-1:0]   p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [PW-1:0]   p_rr_d, p_ii_d, p_ri_d, p_ir_d;
  logic signed [IN_W-1:0] pass_re_q, pass_im_q;
  logic signed [SUMW-1:0] sum_re, sum_im;

  assign p_rr_d = tw_re_i * x_re_i;
  assign p_ii_d = tw_im_i * x_im_i;
  assign p_ri_d = tw_re_i * x_im_i;
  assign p_ir_d = tw_im_i * x_re_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_rr_q    <= p_rr_d;
      p_ii_q    <= p_ii_d;
      p_ri_q    <= p_ri_d;
      p_ir_q    <= p_ir_d;
      pass_re_q <= pass_re_i;
      pass_im_q <= pass_im_i;
    end
  end

  assign sum_re = SUMW'(p_rr_q) - SUMW'(p_ii_q) + RND;
  assign sum_im = SUMW'(p_ri_q) + SUMW'(p_ir_q) + RND;

  // floor after adding half
  assign y_re_o    = sum_re[SUMW-1:FRAC];
  assign y_im_o    = sum_im[SUMW-1:FRAC];
  assign pass_re_o = pass_re_q;
  assign pass_im_o = pass_im_q;

endmodule

// ----- rtl/core/r4fft_bfly.sv -----
// radix-2 merge: sum and difference of a point and a rounded product or j times it, saturated and registered
// no package dependencies
module r4fft_bfly #(
  parameter int IN_W     = 24,
  parameter int RW       = 27,
  parameter int OUT_W    = 26,
  parameter bit ROTATE_J = 1'b0
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [IN_W-1:0]  a_re_i,
  input  logic signed [IN_W-1:0]  a_im_i,
  input  logic signed [RW-1:0]    t_re_i,
  input  logic signed [RW-1:0]    t_im_i,
  output logic signed [OUT_W-1:0] o0_re_o,
  output logic signed [OUT_W-1:0] o0_im_o,
  output logic signed [OUT_W-1:0] o1_re_o,
  output logic signed [OUT_W-1:0] o1_im_o
);

  localparam int SW2 = RW + 2;
  localparam logic signed [SW2-1:0] OMAX = {{(SW2-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [SW2-1:0] OMIN = {{(SW2-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

  function automatic logic signed [OUT_W-1:0] sat(input logic signed [SW2-1:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > OMAX) begin
      r = OMAX[OUT_W-1:0];
    end else if (v < OMIN) begin
      r = OMIN[OUT_W-1:0];
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

  logic signed [SW2-1:0] ar_x, ai_x, tr_x, ti_x, er, ei;
  logic signed [OUT_W-1:0] o0_re_d, o0_im_d, o1_re_d, o1_im_d;
  logic signed [OUT_W-1:0] o0_re_q, o0_im_q, o1_re_q, o1_im_q;

  assign ar_x = SW2'(a_re_i);
  assign ai_x = SW2'(a_im_i);
  assign tr_x = SW2'(t_re_i);
  assign ti_x = SW2'(t_im_i);

  // j*t is (-t_im, t_re)
  assign er = ROTATE_J ? -ti_x : tr_x;
  assign ei = ROTATE_J ? tr_x : ti_x;

  assign o0_re_d = sat(ar_x + er);
  assign o0_im_d = sat(ai_x + ei);
  assign o1_re_d = sat(ar_x - er);
  assign o1_im_d = sat(ai_x - ei);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      o0_re_q <= o0_re_d;
      o0_im_q <= o0_im_d;
      o1_re_q <= o1_re_d;
      o1_im_q <= o1_im_d;
    end
  end

  assign o0_re_o = o0_re_q;
  assign o0_im_o = o0_im_q;
  assign o1_re_o = o1_re_q;
  assign o1_im_o = o1_im_q;

endmodule

// ----- rtl/core/radix4_fft_butterfly_core.sv -----
// top level of the radix-4 fft butterfly: twiddle registers, two lane layers, stall control
// uses r4fft_pkg, r4fft_cmul and r4fft_bfly
//
// One word of four complex points goes in per clock and one word of four transformed points
// comes out per clock while the output is not stalled. A word passes through the two layers
// of complex multiply lanes, each taking a registered product stage and a registered rounding
// and merge stage. Every stage holds under back-pressure independently, so bubbles are
// squeezed out while the output waits. The user must write the twiddles a and b through the
// config port only between bursts; the block itself does not enforce this. Both reset to one.
module radix4_fft_butterfly_core #(
  parameter int SAMPLE_WIDTH      = r4fft_pkg::SAMPLE_WIDTH_DEF,
  parameter int TWIDDLE_FRAC_BITS = r4fft_pkg::TWIDDLE_FRAC_BITS_DEF
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            cfg_we_i,
  input  logic [r4fft_pkg::CFG_IDX_W-1:0]                 cfg_idx_i,
  input  logic [r4fft_pkg::TW_W-1:0]                      cfg_wdata_i,
  input  logic                                            s_axis_tvalid_i,
  output logic                                            s_axis_tready_o,
  // p0_real, p0_imag, p1_real, p1_imag, p2_real, p2_imag, p3_real, p3_imag
  input  logic [r4fft_pkg::NUM_COMP*SAMPLE_WIDTH-1:0]     s_axis_tdata_i,
  output logic                                            m_axis_tvalid_o,
  input  logic                                            m_axis_tready_i,
  // q0_real, q0_imag, q1_real, q1_imag, q2_real, q2_imag, q3_real, q3_imag
  output logic [r4fft_pkg::NUM_COMP*(SAMPLE_WIDTH+2)-1:0] m_axis_tdata_o
);
  import r4fft_pkg::*;

  localparam int OW  = SAMPLE_WIDTH + 2;
  localparam int RW1 = SAMPLE_WIDTH + TW_W + 1 - TWIDDLE_FRAC_BITS;
  localparam int RW2 = OW + TW_W + 1 - TWIDDLE_FRAC_BITS;
  localparam logic [TW_W-1:0] TW_UNIT = {{(TW_W-1){1'b0}}, 1'b1} << TWIDDLE_FRAC_BITS;

  logic [TW_W-1:0] tw_q [NUM_REGS];
  logic [3:0]      vld_q;
  logic [3:0]      en;

  logic signed [SAMPLE_WIDTH-1:0] x [NUM_COMP];
  logic signed [SAMPLE_WIDTH-1:0] p1_re [2], p1_im [2];
  logic signed [RW1-1:0]          y1_re [2], y1_im [2];
  logic signed [OW-1:0]           u_re [4], u_im [4];
  logic signed [OW-1:0]           p2_re [2], p2_im [2];
  logic signed [RW2-1:0]          y2_re [2], y2_im [2];
  logic signed [OW-1:0]           q_re [4], q_im [4];

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tw_q[REG_A_RE] <= TW_UNIT;
      tw_q[REG_A_IM] <= '0;
      tw_q[REG_B_RE] <= TW_UNIT;
      tw_q[REG_B_IM] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_A_RE: tw_q[REG_A_RE] <= cfg_wdata_i;
        REG_A_IM: tw_q[REG_A_IM] <= cfg_wdata_i;
        REG_B_RE: tw_q[REG_B_RE] <= cfg_wdata_i;
        REG_B_IM: tw_q[REG_B_IM] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // stage enables, each stage moves when empty or when the next one moves
  assign en[3] = !vld_q[3] || m_axis_tready_i;
  assign en[2] = !vld_q[2] || en[3];
  assign en[1] = !vld_q[1] || en[2];
  assign en[0] = !vld_q[0] || en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= s_axis_tvalid_i;
      if (en[1]) vld_q[1] <= vld_q[0];
      if (en[2]) vld_q[2] <= vld_q[1];
      if (en[3]) vld_q[3] <= vld_q[2];
    end
  end

  assign s_axis_tready_o = en[0];
  assign m_axis_tvalid_o = vld_q[3];

  always_comb begin
    for (int k = 0; k < NUM_COMP; k++) begin
      x[k] = s_axis_tdata_i[k*SAMPLE_WIDTH +: SAMPLE_WIDTH];
    end
  end

  for (genvar i = 0; i < 2; i++) begin : g_lane
    // layer one: x_i passes, x_(i+2) is multiplied by a
    r4fft_cmul #(
      .IN_W (SAMPLE_WIDTH),
      .FRAC (TWIDDLE_FRAC_BITS),
      .RW   (RW1)
    ) u_cmul_a (
      .clk_i     (clk_i),
      .en_i      (en[0]),
      .tw_re_i   ($signed(tw_q[REG_A_RE])),
      .tw_im_i   ($signed(tw_q[REG_A_IM])),
      .pass_re_i (x[2*i]),
      .pass_im_i (x[2*i+1]),
      .x_re_i    (x[2*i+4]),
      .x_im_i    (x[2*i+5]),
      .pass_re_o (p1_re[i]),
      .pass_im_o (p1_im[i]),
      .y_re_o    (y1_re[i]),
      .y_im_o    (y1_im[i])
    );

    r4fft_bfly #(
      .IN_W     (SAMPLE_WIDTH),
      .RW       (RW1),
      .OUT_W    (OW),
      .ROTATE_J (1'b0)
    ) u_bfly_a (
      .clk_i   (clk_i),
      .en_i    (en[1]),
      .a_re_i  (p1_re[i]),
      .a_im_i  (p1_im[i]),
      .t_re_i  (y1_re[i]),
      .t_im_i  (y1_im[i]),
      .o0_re_o (u_re[i]),
      .o0_im_o (u_im[i]),
      .o1_re_o (u_re[i+2]),
      .o1_im_o (u_im[i+2])
    );

    // layer two: u_(2i) passes, u_(2i+1) is multiplied by b
    r4fft_cmul #(
      .IN_W (OW),
      .FRAC (TWIDDLE_FRAC_BITS),
      .RW   (RW2)
    ) u_cmul_b (
      .clk_i     (clk_i),
      .en_i      (en[2]),
      .tw_re_i   ($signed(tw_q[REG_B_RE])),
      .tw_im_i   ($signed(tw_q[REG_B_IM])),
      .pass_re_i (u_re[2*i]),
      .pass_im_i (u_im[2*i]),
      .x_re_i    (u_re[2*i+1]),
      .x_im_i    (u_im[2*i+1]),
      .pass_re_o (p2_re[i]),
      .pass_im_o (p2_im[i]),
      .y_re_o    (y2_re[i]),
      .y_im_o    (y2_im[i])
    );

    r4fft_bfly #(
      .IN_W     (OW),
      .RW       (RW2),
      .OUT_W    (OW),
      .ROTATE_J (i == 1)
    ) u_bfly_b (
      .clk_i   (clk_i),
      .en_i    (en[3]),
      .a_re_i  (p2_re[i]),
      .a_im_i  (p2_im[i]),
      .t_re_i  (y2_re[i]),
      .t_im_i  (y2_im[i]),
      .o0_re_o (q_re[2*i]),
      .o0_im_o (q_im[2*i]),
      .o1_re_o (q_re[2*i+1]),
      .o1_im_o (q_im[2*i+1])
    );
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      m_axis_tdata_o[(2*k)*OW +: OW]   = q_re[k];
      m_axis_tdata_o[(2*k+1)*OW +: OW] = q_im[k];
    end
  end

endmodule

// ----- rtl/core/r4fft_checker.sv -----
// port-level checks of the butterfly core's stream flow, bound to the top level
// uses r4fft_pkg and radix4_fft_butterfly_core
module r4fft_checker #(
  parameter int SAMPLE_WIDTH = r4fft_pkg::SAMPLE_WIDTH_DEF
) (
  input logic                                            clk_i,
  input logic                                            rst_ni,
  input logic                                            s_axis_tvalid_i,
  input logic                                            s_axis_tready_o,
  input logic                                            m_axis_tvalid_o,
  input logic                                            m_axis_tready_i,
  input logic [r4fft_pkg::NUM_COMP*(SAMPLE_WIDTH+2)-1:0] m_axis_tdata_o
);
  import r4fft_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled output word changed");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output");

  a_flow_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready_i |-> s_axis_tready_o)
    else $error("input stalled while output drains");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) ##1 m_axis_tready_i ##1 m_axis_tready_i
      ##1 m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("word did not reach output in four cycles");

endmodule

bind radix4_fft_butterfly_core r4fft_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_r4fft_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
